/* hdl/b64le_pkg.sv */
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types, character codes and the base64 symbol lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package b64le_pkg;

   localparam int unsigned CHAR_W     = 7;
   localparam int unsigned GROUP_MAX  = 5;
   localparam int unsigned COUNT_W    = 3;

   localparam logic [CHAR_W-1:0] NL_CHAR  = 7'd10;
   localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

   localparam logic [COUNT_W-1:0] GROUP_CHARS    = 3'd4;
   localparam logic [COUNT_W-1:0] GROUP_CHARS_NL = 3'd5;

   localparam logic [5:0] GPL_RESET = 6'd15;

   // one encoded group, slot 0 goes out first
   typedef struct packed {
      logic [GROUP_MAX-1:0][CHAR_W-1:0] chars;
      logic                             eob;     // set on the newline in slot 4
      logic [COUNT_W-1:0]               nchars;  // 4 or 5
   } group_type;

   // map a 6-bit value to its symbol of the standard alphabet
   function automatic logic [CHAR_W-1:0] b64_symbol(input logic [5:0] v);
      logic [CHAR_W-1:0] r;
      if (v < 6'd26) begin
         r = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
         r = 7'd97 + ({1'b0, v} - 7'd26);
      end else if (v < 6'd62) begin
         r = 7'd48 + ({1'b0, v} - 7'd52);
      end else if (v == 6'd62) begin
         r = 7'd43;
      end else begin
         r = 7'd47;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/b64le_packer.sv */
// ----------------------------------------------------------------------------
// b64le_packer
// Collects bytes into 3-byte groups, forms the four symbols plus padding
// and decides the line break. Holds the pending bytes and line position.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_packer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 is_last,
   input  wire logic [5:0]           groups_per_line,
   output      logic                 emit,
   output      b64le_pkg::group_type group
);

   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic [1:0] phase_ff, phase_in;
   logic [5:0] lgc_ff,   lgc_in;

   logic [7:0] b0, b1, b2;
   logic [5:0] limit;
   logic [6:0] cnt;
   logic       newline;

   always_comb begin
      emit = is_last || (phase_ff >= 2'd2);

      b0 = (phase_ff == 2'd0) ? data_byte : pend0_ff;
      b1 = (phase_ff == 2'd1) ? data_byte : ((phase_ff >= 2'd2) ? pend1_ff : 8'd0);
      b2 = (phase_ff >= 2'd2) ? data_byte : 8'd0;

      limit   = (groups_per_line == 6'd0) ? 6'd1 : groups_per_line;
      cnt     = {1'b0, lgc_ff} + 7'd1;
      newline = is_last || (cnt >= {1'b0, limit});

      group.chars[0] = b64le_pkg::b64_symbol(b0[7:2]);
      group.chars[1] = b64le_pkg::b64_symbol({b0[1:0], b1[7:4]});
      group.chars[2] = (phase_ff >= 2'd1) ? b64le_pkg::b64_symbol({b1[3:0], b2[7:6]})
                                          : b64le_pkg::PAD_CHAR;
      group.chars[3] = (phase_ff >= 2'd2) ? b64le_pkg::b64_symbol(b2[5:0])
                                          : b64le_pkg::PAD_CHAR;
      group.chars[4] = b64le_pkg::NL_CHAR;
      group.eob      = is_last;
      group.nchars   = newline ? b64le_pkg::GROUP_CHARS_NL : b64le_pkg::GROUP_CHARS;

      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      phase_in = phase_ff;
      lgc_in   = lgc_ff;
      if (accept) begin
         if (!emit) begin
            // store the byte and advance the phase
            if (phase_ff[0]) begin
               pend1_in = data_byte;
            end else begin
               pend0_in = data_byte;
            end
            phase_in = phase_ff + 2'd1;
         end else begin
            pend0_in = 8'd0;
            pend1_in = 8'd0;
            phase_in = 2'd0;
            lgc_in   = newline ? 6'd0 : cnt[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
      if (reset) begin
         phase_ff <= 2'd0;
         lgc_ff   <= 6'd0;
      end else begin
         phase_ff <= phase_in;
         lgc_ff   <= lgc_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/b64le_serializer.sv */
// ----------------------------------------------------------------------------
// b64le_serializer
// Group buffer of up to five characters drained one per cycle, while the rsp
// side is not stalled, into the response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_serializer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire b64le_pkg::group_type group,
   output      logic                 can_load,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [6:0]           rsp_out_char,
   output      logic                 rsp_end_of_block
);

   localparam int unsigned GM = b64le_pkg::GROUP_MAX;
   localparam int unsigned CW = b64le_pkg::CHAR_W;

   logic [GM-1:0][CW-1:0]          chr_ff,  chr_in;
   logic [GM-1:0]                  eob_ff,  eob_in;
   logic [b64le_pkg::COUNT_W-1:0]  left_ff, left_in;
   logic                           vld_ff,  vld_in;
   logic [CW-1:0]                  och_ff,  och_in;
   logic                           oeb_ff,  oeb_in;

   logic out_free;
   logic move;

   always_comb begin
      out_free = !vld_ff || rsp_ready;
      move     = out_free && (left_ff != '0);
      can_load = (left_ff == '0) || ((left_ff == 3'd1) && out_free);

      chr_in  = chr_ff;
      eob_in  = eob_ff;
      left_in = left_ff;
      vld_in  = vld_ff;
      och_in  = och_ff;
      oeb_in  = oeb_ff;

      if (out_free) begin
         vld_in = 1'b0;
      end
      if (move) begin
         vld_in  = 1'b1;
         och_in  = chr_ff[0];
         oeb_in  = eob_ff[0];
         chr_in  = {{CW{1'b0}}, chr_ff[GM-1:1]};
         eob_in  = {1'b0, eob_ff[GM-1:1]};
         left_in = left_ff - 3'd1;
      end
      if (load) begin
         chr_in  = group.chars;
         eob_in  = {group.eob, {(GM-1){1'b0}}};
         left_in = group.nchars;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff <= chr_in;
      eob_ff <= eob_in;
      och_ff <= och_in;
      oeb_ff <= oeb_in;
      if (reset) begin
         left_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         left_ff <= left_in;
         vld_ff  <= vld_in;
      end
   end

   assign rsp_valid        = vld_ff;
   assign rsp_out_char     = och_ff;
   assign rsp_end_of_block = oeb_ff;

endmodule

`default_nettype wire

/* hdl/base64_line_encoder_unit.sv */
// ----------------------------------------------------------------------------
// base64_line_encoder_unit
// Streaming base64 encoder with a newline every groups_per_line groups (0 acts as 1) and after the last group.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+-----------------------
//  req     | req_valid/ready, data_byte, is_last     | one raw byte per request
//  rsp     | rsp_valid/ready, out_char, end_of_block | one ASCII character
//  csr     | csr_valid/ready, groups_per_line        | line length in groups
//
//  A byte that only fills the pending group is taken in any cycle. A byte
//  that closes a group loads 4 or 5 characters into the group buffer; the
//  next such byte waits until the buffer drains, one character per cycle
//  while rsp is not stalled. The closing request loads the group buffer,
//  and the first character passes from there into the output register.
//  Reset is synchronous and clears the phase and the line position, empties
//  the buffer and the output register; the line length returns to 15. A
//  stalled rsp side holds back a closing byte while the buffer is not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_line_encoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_is_last,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [6:0] rsp_out_char,
   output      logic       rsp_end_of_block,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [5:0] csr_groups_per_line
);

   logic [5:0] gpl_ff, gpl_in;

   logic                 emit;
   logic                 can_load;
   logic                 req_accept;
   b64le_pkg::group_type group;

   // line length register, writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      gpl_in = gpl_ff;
      if (csr_valid) begin
         gpl_in = csr_groups_per_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpl_ff <= b64le_pkg::GPL_RESET;
      end else begin
         gpl_ff <= gpl_in;
      end
   end

   // a byte that emits nothing never waits on the buffer
   assign req_ready  = can_load || !emit;
   assign req_accept = req_valid && req_ready;

   b64le_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .data_byte       (req_data_byte),
      .is_last         (req_is_last),
      .groups_per_line (gpl_ff),
      .emit            (emit),
      .group           (group)
   );

   b64le_serializer u_serializer (
      .clock            (clock),
      .reset            (reset),
      .load             (req_accept && emit),
      .group            (group),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_end_of_block (rsp_end_of_block)
   );

endmodule

`default_nettype wire

/* hdl/b64le_checker.sv */
// ----------------------------------------------------------------------------
// b64le_checker
// Port-level checks for the base64 line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] rsp_out_char,
   input wire logic       rsp_end_of_block
);

   // a stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_char) && $stable(rsp_end_of_block))
      else $error("rsp changed while stalled");

   // end of block only marks a newline
   a_eob_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_block |-> rsp_out_char == b64le_pkg::NL_CHAR)
      else $error("end_of_block on a non-newline character");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind base64_line_encoder_unit b64le_checker u_b64le_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_char     (rsp_out_char),
   .rsp_end_of_block (rsp_end_of_block)
);

`default_nettype wire
